// ----- rtl/dad_pkg.sv -----
// Shared types, constants and calendar functions for the date add-days block.
`timescale 1ns / 1ps
package dad_pkg;

	// Field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int OFF_W    = 17;
	localparam int STATUS_W = 2;
	// Running day count: day of month plus a full-range offset
	localparam int DACC_W   = 18;
	// Year modulo 400
	localparam int Y400_W   = 9;

	localparam int MAX_YEAR   = 9999;
	localparam int MAX_OFFSET = 65535;

	localparam logic [YEAR_W-1:0]  MAX_YEAR_V = YEAR_W'(MAX_YEAR);
	localparam logic [YEAR_W-1:0]  YEAR_ONE   = YEAR_W'(1);
	localparam logic [Y400_W-1:0]  Y400_LAST  = Y400_W'(399);
	localparam logic [YEAR_W-1:0]  CYCLE_400  = YEAR_W'(400);
	localparam logic [MONTH_W-1:0] JAN        = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] FEB        = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] DEC        = MONTH_W'(12);

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_YEAR_OOR = 2'd2;

	// Month lengths for a common year, unused codes read as zero
	localparam logic [DAY_W-1:0] MONTH_LEN [0:15] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	// Leap year from year mod 400: divisible by 4, and not a century unless
	// the 400-year mark
	function automatic logic is_leap(input logic [Y400_W-1:0] y400);
		is_leap = (y400[1:0] == 2'b00) && (y400 != Y400_W'(100)) &&
			(y400 != Y400_W'(200)) && (y400 != Y400_W'(300));
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
		input logic leap);
		if (month == FEB && leap) begin
			days_in = DAY_W'(29);
		end else begin
			days_in = MONTH_LEN[month];
		end
	endfunction

	// Walk state handed to the carry/borrow unit
	typedef struct packed {
		logic                     fwd;
		logic signed [DACC_W-1:0] day;
		logic [MONTH_W-1:0]       month;
		logic [YEAR_W-1:0]        year;
		logic [Y400_W-1:0]        y400;
	} step_in_t;

	// Result of one carry/borrow step
	typedef struct packed {
		logic                     done;
		logic                     ovf;
		logic signed [DACC_W-1:0] day;
		logic [MONTH_W-1:0]       month;
		logic [YEAR_W-1:0]        year;
		logic [Y400_W-1:0]        y400;
	} step_out_t;

endpackage

// ----- rtl/dad_step.sv -----
// Month carry/borrow unit: one shared add of a month length per step.
`timescale 1ns / 1ps
module dad_step
	import dad_pkg::*;
(
	input  step_in_t  si,
	output step_out_t so
);

	logic [MONTH_W-1:0]       prev_month, next_month, sel_month;
	logic [YEAR_W-1:0]        prev_year, next_year;
	logic [Y400_W-1:0]        prev_y400, next_y400, sel_y400;
	logic [DAY_W-1:0]         dim;
	logic signed [DACC_W-1:0] dim_ext, addend, sum;

	// Neighbor months, with year and year-mod-400 wrap
	always_comb begin
		if (si.month == JAN) begin
			prev_month = DEC;
			prev_year  = si.year - YEAR_ONE;
			prev_y400  = (si.y400 == '0) ? Y400_LAST : si.y400 - Y400_W'(1);
		end else begin
			prev_month = si.month - MONTH_W'(1);
			prev_year  = si.year;
			prev_y400  = si.y400;
		end
		if (si.month == DEC) begin
			next_month = JAN;
			next_year  = si.year + YEAR_ONE;
			next_y400  = (si.y400 == Y400_LAST) ? '0 : si.y400 + Y400_W'(1);
		end else begin
			next_month = si.month + MONTH_W'(1);
			next_year  = si.year;
			next_y400  = si.y400;
		end
	end

	// Forward subtracts the current month, backward adds the previous one
	assign sel_month = si.fwd ? si.month : prev_month;
	assign sel_y400  = si.fwd ? si.y400 : prev_y400;
	assign dim       = days_in(sel_month, is_leap(sel_y400));
	assign dim_ext   = signed'({{(DACC_W-DAY_W){1'b0}}, dim});
	assign addend    = si.fwd ? -dim_ext : dim_ext;
	assign sum       = si.day + addend;

	always_comb begin
		so.day = sum;
		if (si.fwd) begin
			so.done  = (sum <= 0);
			so.ovf   = (si.month == DEC) && (si.year >= MAX_YEAR_V);
			so.month = next_month;
			so.year  = next_year;
			so.y400  = next_y400;
		end else begin
			so.done  = (si.day > 0);
			so.ovf   = (si.month == JAN) && (si.year <= YEAR_ONE);
			so.month = prev_month;
			so.year  = prev_year;
			so.y400  = prev_y400;
		end
	end

endmodule

// ----- rtl/date_add_days.sv -----
// Top level: sequencer, walk registers and output register for date plus days.
// Each transaction is accepted, has its year reduced mod 400 (R = year/400 subtractions,
// at most 40) and its date checked, walks the months (M = months carried or borrowed,
// about 2160 at 65535 days) and then loads the output register; an invalid date skips
// the walk. One transaction at a time; the walk steps one month per cycle.
// Reset: arst_n asynchronous, active low; clears sequencer and output valid.
`timescale 1ns / 1ps
module date_add_days
	import dad_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [YEAR_W-1:0]        in_year,
	input  logic [MONTH_W-1:0]       in_month,
	input  logic [DAY_W-1:0]         in_day,
	input  logic signed [OFF_W-1:0]  offset_days,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [YEAR_W-1:0]        out_year,
	output logic [MONTH_W-1:0]       out_month,
	output logic [DAY_W-1:0]         out_day,
	output logic [STATUS_W-1:0]      status
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MOD   = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic signed [DACC_W-1:0] OFF_MAX = DACC_W'(MAX_OFFSET);

	logic [2:0]               state_q;
	logic [YEAR_W-1:0]        year_q, rem_q;
	logic [MONTH_W-1:0]       month_q;
	logic signed [DACC_W-1:0] day_q, off_q;
	logic                     fwd_q;
	logic [STATUS_W-1:0]      st_q;

	logic                     out_valid_q;
	logic [YEAR_W-1:0]        out_year_q;
	logic [MONTH_W-1:0]       out_month_q;
	logic [DAY_W-1:0]         out_day_q;
	logic [STATUS_W-1:0]      status_q;

	logic                     in_acc, out_free, date_ok;
	logic signed [DACC_W-1:0] off_ext, off_sat;
	logic [DAY_W-1:0]         dim_chk;
	step_in_t                 step_i;
	step_out_t                step_o;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Offset clamp to +/- MAX_OFFSET
	assign off_ext = signed'({offset_days[OFF_W-1], offset_days});
	always_comb begin
		if (off_ext > OFF_MAX) begin
			off_sat = OFF_MAX;
		end else if (off_ext < -OFF_MAX) begin
			off_sat = -OFF_MAX;
		end else begin
			off_sat = off_ext;
		end
	end

	// Input date check, with year mod 400 already reduced
	assign dim_chk = days_in(month_q, is_leap(rem_q[Y400_W-1:0]));
	assign date_ok = (year_q >= YEAR_ONE) && (year_q <= MAX_YEAR_V) &&
		(month_q >= JAN) && (month_q <= DEC) && (day_q >= 1) &&
		(day_q <= signed'({{(DACC_W-DAY_W){1'b0}}, dim_chk}));

	assign step_i.fwd   = fwd_q;
	assign step_i.day   = day_q;
	assign step_i.month = month_q;
	assign step_i.year  = year_q;
	assign step_i.y400  = rem_q[Y400_W-1:0];

	dad_step u_step (
		.si(step_i),
		.so(step_o)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_MOD;
				end
				S_MOD: begin
					if (rem_q < CYCLE_400) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= date_ok ? S_WALK : S_DONE;
				end
				S_WALK: begin
					if (step_o.done || step_o.ovf) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					year_q  <= in_year;
					rem_q   <= in_year;
					month_q <= in_month;
					day_q   <= signed'({{(DACC_W-DAY_W){1'b0}}, in_day});
					off_q   <= off_sat;
				end
			end
			S_MOD: begin
				if (rem_q >= CYCLE_400) rem_q <= rem_q - CYCLE_400;
			end
			S_CHECK: begin
				day_q <= day_q + off_q;
				fwd_q <= !off_q[DACC_W-1];
				st_q  <= date_ok ? ST_OK : ST_BAD_DATE;
			end
			S_WALK: begin
				if (step_o.done) begin
					st_q <= ST_OK;
				end else if (step_o.ovf) begin
					st_q <= ST_YEAR_OOR;
				end else begin
					day_q   <= step_o.day;
					month_q <= step_o.month;
					year_q  <= step_o.year;
					rem_q   <= {{(YEAR_W-Y400_W){1'b0}}, step_o.y400};
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= st_q;
			if (st_q == ST_OK) begin
				out_year_q  <= year_q;
				out_month_q <= month_q;
				out_day_q   <= day_q[DAY_W-1:0];
			end else begin
				out_year_q  <= '0;
				out_month_q <= '0;
				out_day_q   <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_year  = out_year_q;
	assign out_month = out_month_q;
	assign out_day   = out_day_q;
	assign status    = status_q;

	// Checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
			(out_year == '0 && out_month == '0 && out_day == '0))
		else $error("error status with nonzero date");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |->
			(out_month >= JAN && out_month <= DEC && out_day != '0 &&
			 out_year >= YEAR_ONE && out_year <= MAX_YEAR_V))
		else $error("ok result outside calendar range");

	a_accept_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MOD))
		else $error("accepted transaction did not start reduction");

	a_walk_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (month_q >= JAN && month_q <= DEC &&
			year_q >= YEAR_ONE && rem_q < CYCLE_400))
		else $error("walk state out of range");

endmodule

// ----- bench/tb_date_add_days.sv -----
// Testbench for date_add_days: directed and random date shifts against a calendar model.
`timescale 1ns / 1ps
module tb_date_add_days;
	import dad_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 2400;

	typedef struct {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [STATUS_W-1:0] st;
	} date_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [YEAR_W-1:0]       in_year;
	logic [MONTH_W-1:0]      in_month;
	logic [DAY_W-1:0]        in_day;
	logic signed [OFF_W-1:0] offset_days;
	logic                    out_valid;
	logic                    out_stall;
	logic [YEAR_W-1:0]       out_year;
	logic [MONTH_W-1:0]      out_month;
	logic [DAY_W-1:0]        out_day;
	logic [STATUS_W-1:0]     status;

	date_result_t pending_dates[$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	bit           idle_en = 1'b1;
	bit           hold_results = 1'b0;

	date_add_days uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_year    (in_year),
		.in_month   (in_month),
		.in_day     (in_day),
		.offset_days(offset_days),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day),
		.status     (status)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Days in a month, Gregorian leap rule for February
	function automatic int month_days(input int year, input int month);
		bit leap;
		leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
		case (month)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return leap ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	// Expected result of shifting a date by a day count
	function automatic date_result_t shift_date(input logic [YEAR_W-1:0] y,
		input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
		input logic signed [OFF_W-1:0] off);
		int           year;
		int           month;
		int           day;
		int           delta;
		date_result_t r;
		year  = y;
		month = m;
		day   = d;
		delta = off;
		// magnitude clamps to the largest supported offset
		if (delta > MAX_OFFSET)
			delta = MAX_OFFSET;
		if (delta < -MAX_OFFSET)
			delta = -MAX_OFFSET;
		r.st = ST_OK;
		if (year < 1 || year > MAX_YEAR || month < 1 || month > 12 || day < 1 ||
			day > month_days(year, month)) begin
			r.st = ST_BAD_DATE;
		end else begin
			day += delta;
			if (delta >= 0) begin
				// carry whole months forward
				while (day > month_days(year, month)) begin
					day -= month_days(year, month);
					if (month == DEC) begin
						month = JAN;
						year++;
						if (year > MAX_YEAR) begin
							r.st = ST_YEAR_OOR;
							break;
						end
					end else begin
						month++;
					end
				end
			end else begin
				// borrow whole months backward
				while (day < 1) begin
					if (month == JAN) begin
						month = DEC;
						year--;
						if (year < 1) begin
							r.st = ST_YEAR_OOR;
							break;
						end
					end else begin
						month--;
					end
					day += month_days(year, month);
				end
			end
		end
		if (r.st != ST_OK) begin
			year  = 0;
			month = 0;
			day   = 0;
		end
		r.year  = YEAR_W'(year);
		r.month = MONTH_W'(month);
		r.day   = DAY_W'(day);
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Offer one date and wait for the transaction to be taken
	task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0] d, input logic signed [OFF_W-1:0] off);
		int gap;
		gap = idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_year     <= y;
		in_month    <= m;
		in_day      <= d;
		offset_days <= off;
		do @(posedge clk); while (in_stall);
		pending_dates.push_back(shift_date(y, m, d, off));
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	// Receiver side: random stalls, plus a long counted hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_results) begin
				hold_results = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		date_result_t exp_date;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				exp_date = pending_dates.pop_front();
				if (out_year !== exp_date.year)
					report_mismatch($sformatf("out_year got %0d expected %0d",
						out_year, exp_date.year));
				if (out_month !== exp_date.month)
					report_mismatch($sformatf("out_month got %0d expected %0d",
						out_month, exp_date.month));
				if (out_day !== exp_date.day)
					report_mismatch($sformatf("out_day got %0d expected %0d",
						out_day, exp_date.day));
				if (status !== exp_date.st)
					report_mismatch($sformatf("status got %0d expected %0d",
						status, exp_date.st));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** date_add_days: FAILED **");
			$finish;
		end
	end

	// February lengths across the leap rule
	task automatic test_leap_years();
		send_date(14'd2024, 4'd2, 5'd28, 17'sd1);
		send_date(14'd2023, 4'd2, 5'd28, 17'sd1);
		send_date(14'd1900, 4'd2, 5'd28, 17'sd1);
		send_date(14'd2000, 4'd2, 5'd29, 17'sd0);
		send_date(14'd2024, 4'd3, 5'd1, -17'sd1);
		send_date(14'd2023, 4'd12, 5'd31, 17'sd366);
	endtask

	// Walks that run past the first or last supported year
	task automatic test_year_limits();
		send_date(14'd9999, 4'd12, 5'd31, 17'sd1);
		send_date(14'd1, 4'd1, 5'd1, -17'sd1);
		send_date(14'd9999, 4'd1, 5'd1, 17'sd65535);
		send_date(14'd1, 4'd12, 5'd31, -17'sd65535);
		send_date(14'd1, 4'd1, 5'd1, 17'sd65535);
	endtask

	// Dates that do not exist, plus one valid month-end date
	task automatic test_bad_dates();
		send_date(14'd0, 4'd6, 5'd15, 17'sd10);
		send_date(14'd16383, 4'd15, 5'd31, -17'sd1);
		send_date(14'd10000, 4'd1, 5'd1, 17'sd0);
		send_date(14'd2020, 4'd0, 5'd1, 17'sd1);
		send_date(14'd2020, 4'd13, 5'd1, 17'sd1);
		send_date(14'd2020, 4'd5, 5'd0, 17'sd1);
		send_date(14'd2020, 4'd4, 5'd31, 17'sd1);
		send_date(14'd2023, 4'd2, 5'd29, 17'sd1);
		send_date(14'd2021, 4'd1, 5'd31, 17'sd0);
	endtask

	// Largest offsets, including the one pattern that clamps
	task automatic test_offset_saturation();
		send_date(14'd9999, 4'd12, 5'd31, 17'sh10000);
		send_date(14'd9999, 4'd12, 5'd31, -17'sd65535);
		send_date(14'd5000, 4'd6, 5'd15, 17'sd65535);
	endtask

	// Hold the result side so the block backs up into its input
	task automatic test_output_hold();
		int i;
		wait_results_drained();
		hold_results = 1'b1;
		while (out_stall !== 1'b1) @(posedge clk);
		for (i = 0; i < 6; i++)
			send_date(YEAR_W'($urandom_range(1, MAX_YEAR)), MONTH_W'($urandom_range(1, 12)),
				DAY_W'($urandom_range(1, 28)), OFF_W'($urandom_range(0, 40) - 20));
	endtask

	// Random dates: mostly well-formed, some raw field noise
	task automatic test_random_dates(input int count);
		int                      i;
		int                      r;
		int                      len;
		int                      delta;
		logic [YEAR_W-1:0]       y;
		logic [MONTH_W-1:0]      m;
		logic [DAY_W-1:0]        d;
		logic signed [OFF_W-1:0] off;
		for (i = 0; i < count; i++) begin
			// alternate between stretches with and without idle cycles
			idle_en = ((i / 60) % 2) == 0;
			if ($urandom_range(0, 99) < 20) begin
				y   = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
				m   = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
				d   = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
				off = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					y = YEAR_W'($urandom_range(1, 3));
				else if (r < 20)
					y = YEAR_W'($urandom_range(MAX_YEAR - 2, MAX_YEAR));
				else
					y = YEAR_W'($urandom_range(1, MAX_YEAR));
				m   = MONTH_W'($urandom_range(1, 12));
				len = month_days(y, m);
				d   = ($urandom_range(0, 1) == 0) ? DAY_W'($urandom_range(len - 2, len)) :
					DAY_W'($urandom_range(1, len));
				// small offsets dominate; the walk time grows with the month count
				r = $urandom_range(0, 99);
				if (r < 55)
					delta = $urandom_range(0, 120) - 60;
				else if (r < 80)
					delta = $urandom_range(0, 3000) - 1500;
				else if (r < 92)
					delta = $urandom_range(0, 16000) - 8000;
				else
					delta = $urandom_range(0, (1 << OFF_W) - 1);
				off = OFF_W'(delta);
			end
			send_date(y, m, d, off);
		end
		idle_en = 1'b1;
	endtask

	// Main sequence
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_year     <= '0;
		in_month    <= '0;
		in_day      <= '0;
		offset_days <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_leap_years();
		test_year_limits();
		test_bad_dates();
		test_offset_saturation();
		test_output_hold();
		test_random_dates(240);

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** date_add_days: PASSED **");
		end else begin
			$display("** date_add_days: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dad_pkg.sv
rtl/dad_step.sv
rtl/date_add_days.sv
bench/tb_date_add_days.sv
